@@ rtl/mie_pkg.sv @@
// ----------------------------------------------------------------------------
// mie_pkg
// Shared constants and types for the modular inverse block: default width,
// modulus reset value, sequencer states and datapath control and status.
// ----------------------------------------------------------------------------
`default_nettype none

package mie_pkg;

  localparam int          MIE_WIDTH     = 32;
  localparam logic [63:0] MIE_MOD_RESET = 64'd1000000007;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ALIGN,
    ST_DIVIDE,
    ST_SWAP,
    ST_FINISH
  } state_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_LOAD,
    OP_START,
    OP_ALIGN,
    OP_DIV,
    OP_SWAP
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   res_load;
  } ctrl_t;

  typedef struct packed {
    logic r1_zero;
    logic align_more;
    logic k_zero;
  } status_t;

endpackage

`default_nettype wire

@@ rtl/mie_datapath.sv @@
// ----------------------------------------------------------------------------
// mie_datapath
// Remainder and coefficient registers around one shared shift-subtract unit.
// Each Euclid step aligns the divisor, then retires one quotient bit a cycle
// while the product q*s1 is built MSB first in the same pass.
// ----------------------------------------------------------------------------
`default_nettype none

module mie_datapath import mie_pkg::*; #(
  parameter int WIDTH = MIE_WIDTH
) (
  input  wire logic             clk,
  input  wire dp_op_t           op,
  input  wire logic [WIDTH-1:0] in_value,
  input  wire logic [WIDTH-1:0] modulus,
  output status_t               status,
  output logic      [WIDTH-1:0] inverse,
  output logic      [WIDTH-1:0] gcd
);

  localparam int KW = $clog2(WIDTH);

  logic [WIDTH-1:0] r0_r, r0_nxt;
  logic [WIDTH-1:0] r1_r, r1_nxt;
  logic [WIDTH-1:0] d_r, d_nxt;
  logic [WIDTH:0]   s0_r, s0_nxt;
  logic [WIDTH:0]   s1_r, s1_nxt;
  logic [WIDTH:0]   p_r, p_nxt;
  logic [KW-1:0]    k_r, k_nxt;

  logic [WIDTH:0]   d_dbl;
  logic [WIDTH:0]   diff;
  logic             ge;
  logic [WIDTH:0]   p_step;
  logic [WIDTH:0]   fix;

  // shared unit: compare/subtract on the remainder, shift-add on the product
  assign d_dbl  = {d_r, 1'b0};
  assign diff   = {1'b0, r0_r} - {1'b0, d_r};
  assign ge     = ~diff[WIDTH];
  assign p_step = {p_r[WIDTH-1:0], 1'b0} + (ge ? s1_r : '0);

  assign status.r1_zero    = (r1_r == '0);
  assign status.align_more = (d_dbl <= {1'b0, r0_r});
  assign status.k_zero     = (k_r == '0);

  // |s0| <= m at the end, so one add folds a negative coefficient into 0..m-1
  assign fix = {1'b0, modulus} + s0_r;
  assign gcd = r0_r;

  always_comb begin
    if (modulus == '0) begin
      inverse = '0;
    end else if (s0_r[WIDTH]) begin
      inverse = fix[WIDTH-1:0];
    end else if (s0_r[WIDTH-1:0] == modulus) begin
      inverse = '0;
    end else begin
      inverse = s0_r[WIDTH-1:0];
    end
  end

  always_comb begin
    r0_nxt = r0_r;
    r1_nxt = r1_r;
    d_nxt  = d_r;
    s0_nxt = s0_r;
    s1_nxt = s1_r;
    p_nxt  = p_r;
    k_nxt  = k_r;
    unique case (op)
      OP_HOLD: begin
      end
      OP_LOAD: begin
        r0_nxt = in_value;
        r1_nxt = modulus;
        s0_nxt = (WIDTH+1)'(1);
        s1_nxt = '0;
      end
      OP_START: begin
        d_nxt = r1_r;
        p_nxt = '0;
        k_nxt = '0;
      end
      OP_ALIGN: begin
        d_nxt = d_dbl[WIDTH-1:0];
        k_nxt = k_r + KW'(1);
      end
      OP_DIV: begin
        if (ge) begin
          r0_nxt = diff[WIDTH-1:0];
        end
        p_nxt = p_step;
        d_nxt = d_r >> 1;
        k_nxt = k_r - KW'(1);
      end
      OP_SWAP: begin
        // r0 holds the remainder after the divide pass
        r0_nxt = r1_r;
        r1_nxt = r0_r;
        s0_nxt = s1_r;
        s1_nxt = s0_r - p_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    r0_r <= r0_nxt;
    r1_r <= r1_nxt;
    d_r  <= d_nxt;
    s0_r <= s0_nxt;
    s1_r <= s1_nxt;
    p_r  <= p_nxt;
    k_r  <= k_nxt;
  end

endmodule

`default_nettype wire

@@ rtl/mie_ctrl.sv @@
// ----------------------------------------------------------------------------
// mie_ctrl
// Sequencer for the Euclid loop: check, align divisor, divide bit by bit,
// swap remainders and coefficients, then hand the result to the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module mie_ctrl import mie_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  input  wire logic    out_free,
  input  wire status_t status,
  output logic         in_ready,
  output ctrl_t        ctrl,
  output state_t       state
);

  state_t state_r, state_nxt;

  assign state = state_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_CHECK;
      ST_CHECK:  state_nxt = status.r1_zero ? ST_FINISH : ST_ALIGN;
      ST_ALIGN:  if (!status.align_more) state_nxt = ST_DIVIDE;
      ST_DIVIDE: if (status.k_zero) state_nxt = ST_SWAP;
      ST_SWAP:   state_nxt = ST_CHECK;
      ST_FINISH: if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    ctrl.op       = OP_HOLD;
    ctrl.res_load = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) ctrl.op = OP_LOAD;
      end
      ST_CHECK:  if (!status.r1_zero) ctrl.op = OP_START;
      ST_ALIGN:  if (status.align_more) ctrl.op = OP_ALIGN;
      ST_DIVIDE: ctrl.op = OP_DIV;
      ST_SWAP:   ctrl.op = OP_SWAP;
      ST_FINISH: ctrl.res_load = out_free;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/modular_inverse_ext_euclid.sv @@
// ----------------------------------------------------------------------------
// modular_inverse_ext_euclid
// Modular inverse and gcd of a value against a configured modulus, by the
// extended Euclidean algorithm on a shared shift-subtract unit.
// ----------------------------------------------------------------------------
// Each Euclid step checks, doubles the divisor k times (k is 0 when the
//   quotient is 0 or 1), divides bit by bit, then swaps.
// Throughput: one transaction at a time; the divide unit sets the pace.
//   A finished result waits in the output register while the next starts.
// Reset: synchronous rst_n clears control and loads modulus 1000000007.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_inverse_ext_euclid import mie_pkg::*; #(
  parameter int WIDTH = MIE_WIDTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [WIDTH-1:0] cfg_wdata,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [WIDTH-1:0] in_value,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic      [WIDTH-1:0] out_inverse,
  output logic      [WIDTH-1:0] out_gcd
);

  logic [WIDTH-1:0] mod_r;
  logic             out_valid_r, out_valid_nxt;
  logic [WIDTH-1:0] inverse_r, gcd_r;
  logic             out_free;
  ctrl_t            ctrl;
  status_t          status;
  state_t           state;
  logic [WIDTH-1:0] dp_inverse, dp_gcd;

  assign out_free    = ~out_valid_r | out_ready;
  assign out_valid   = out_valid_r;
  assign out_inverse = inverse_r;
  assign out_gcd     = gcd_r;

  mie_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_free (out_free),
    .status   (status),
    .in_ready (in_ready),
    .ctrl     (ctrl),
    .state    (state)
  );

  mie_datapath #(
    .WIDTH (WIDTH)
  ) u_datapath (
    .clk      (clk),
    .op       (ctrl.op),
    .in_value (in_value),
    .modulus  (mod_r),
    .status   (status),
    .inverse  (dp_inverse),
    .gcd      (dp_gcd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= MIE_MOD_RESET[WIDTH-1:0];
    end else if (cfg_we) begin
      mod_r <= cfg_wdata;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctrl.res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.res_load) begin
      inverse_r <= dp_inverse;
      gcd_r     <= dp_gcd;
    end
  end

  // accepted transaction starts the loop; no second accept right behind it
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while loop busy");

  // result only written when the output register is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.res_load |-> (!out_valid_r || out_ready))
    else $error("pending result overwritten");

  // divisor stays nonzero throughout align and divide
  a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state == ST_ALIGN || state == ST_DIVIDE) |-> !status.r1_zero)
    else $error("divide with zero divisor");

  // a result lands in the output register the cycle after it is loaded
  a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.res_load |=> out_valid)
    else $error("loaded result not presented");

endmodule

`default_nettype wire

@@ tb/tb_modular_inverse_ext_euclid.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_modular_inverse_ext_euclid
// Drives values into the modular inverse block under a series of moduli and
// compares every inverse and gcd against an extended Euclid predictor kept in
// a scoreboard. Both handshakes stall at random, with one long output hold-off.
// ----------------------------------------------------------------------------

import mie_pkg::*;

class inverse_scoreboard;
  typedef struct packed {
    logic [MIE_WIDTH-1:0] inverse;
    logic [MIE_WIDTH-1:0] gcd;
  } inv_result_t;

  logic [MIE_WIDTH-1:0] modulus;
  inv_result_t          pending_results[$];
  int                   mismatches;
  int                   checked;

  function new();
    modulus    = MIE_MOD_RESET[MIE_WIDTH-1:0];
    mismatches = 0;
    checked    = 0;
  endfunction

  // Quotient-based extended Euclid; coefficient kept modulo 2^64.
  function void euclid_inverse(input logic [63:0] a, input logic [63:0] m,
                               output logic [63:0] g, output logic [63:0] inv);
    logic [63:0] r0, r1, s0, s1, q, t, mag, rem;
    logic        neg;
    r0 = a;
    r1 = m;
    s0 = 64'd1;
    s1 = 64'd0;
    while (r1 != 64'd0) begin
      q  = r0 / r1;
      t  = r0 - q * r1;
      r0 = r1;
      r1 = t;
      t  = s0 - q * s1;
      s0 = s1;
      s1 = t;
    end
    g = r0;
    if (m == 64'd0) begin
      inv = 64'd0;
    end else begin
      neg = s0[63];
      mag = neg ? (64'd0 - s0) : s0;
      rem = mag % m;
      if (neg && rem != 64'd0) rem = m - rem;
      inv = rem;
    end
  endfunction

  function void note_value(input logic [MIE_WIDTH-1:0] value);
    logic [63:0] g, inv;
    inv_result_t exp_res;
    euclid_inverse({32'd0, value}, {32'd0, modulus}, g, inv);
    exp_res.inverse = inv[MIE_WIDTH-1:0];
    exp_res.gcd     = g[MIE_WIDTH-1:0];
    pending_results.push_back(exp_res);
  endfunction

  function void check_result(input logic [MIE_WIDTH-1:0] inverse,
                             input logic [MIE_WIDTH-1:0] gcd);
    inv_result_t exp_res;
    if (pending_results.size() == 0) begin
      $error("unexpected result transaction: inverse=%0h gcd=%0h", inverse, gcd);
      mismatches++;
      return;
    end
    exp_res = pending_results.pop_front();
    checked++;
    if (inverse !== exp_res.inverse) begin
      $error("inverse mismatch: expected %0h actual %0h", exp_res.inverse, inverse);
      mismatches++;
    end
    if (gcd !== exp_res.gcd) begin
      $error("gcd mismatch: expected %0h actual %0h", exp_res.gcd, gcd);
      mismatches++;
    end
  endfunction

  function int pending_count();
    return pending_results.size();
  endfunction
endclass

module tb_modular_inverse_ext_euclid;

  localparam int W               = MIE_WIDTH;
  localparam int NUM_PHASES      = 10;
  localparam int ITEMS_PER_PHASE = 165;
  localparam int STALL_LIMIT     = 20000;
  localparam int LONG_HOLD       = 1500;

  logic         clk;
  logic         rst_n;
  logic         cfg_we;
  logic [W-1:0] cfg_wdata;
  logic         in_valid;
  logic         in_ready;
  logic [W-1:0] in_value;
  logic         out_valid;
  logic         out_ready;
  logic [W-1:0] out_inverse;
  logic [W-1:0] out_gcd;

  inverse_scoreboard sb;

  int send_idle_pct;
  int recv_idle_pct;
  int hold_requests = 0;
  int holds_served  = 0;
  int hold_left     = 0;
  int stall_cycles  = 0;
  int total_sent    = 0;
  int moduli_used   = 0;

  modular_inverse_ext_euclid #(.WIDTH(W)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_inverse(out_inverse),
    .out_gcd    (out_gcd)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Transaction monitor: note inputs before checking outputs of the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_value(in_value);
      if (out_valid && out_ready) sb.check_result(out_inverse, out_gcd);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("modular_inverse_ext_euclid verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Receiver: random back-pressure, plus a long hold-off on request.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_requests != holds_served) begin
      out_ready    <= 1'b0;
      hold_left    <= LONG_HOLD;
      holds_served <= holds_served + 1;
    end else if (rst_n) begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_value(input logic [W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    total_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending_count() != 0) @(negedge clk);
  endtask

  task automatic write_modulus(input logic [W-1:0] m);
    drain_results();
    repeat (4) @(negedge clk);
    cfg_we     <= 1'b1;
    cfg_wdata  <= m;
    sb.modulus = m;
    @(negedge clk);
    cfg_we <= 1'b0;
    moduli_used++;
  endtask

  function automatic logic [W-1:0] phase_modulus(input int p);
    case (p)
      0:       return MIE_MOD_RESET[W-1:0];
      1:       return $urandom | 32'd1;
      2:       return 32'd2;
      3:       return 32'hFFFF_FFFF;
      4:       return $urandom_range(1000, 3);
      5:       return 32'h8000_0000;
      6:       return $urandom_range(32'hFFFF_FFFF, 1);
      7:       return 32'd1;
      8:       return 32'hFFFF_FFFE;
      default: return 32'd65536;
    endcase
  endfunction

  // Full-range values in four picks of ten; the rest are small, near the
  // modulus, multiples of it, sharing small factors with it, zero or near 2^32-1.
  function automatic logic [W-1:0] pick_value(input logic [W-1:0] m);
    logic [W-1:0] f;
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom;
      4:          return $urandom_range(255);
      5:          return m + $urandom_range(2) - 32'd1;
      6:          return m * $urandom_range(32'hFFFF_FFFF / m);
      7: begin
        if (m % 2 == 0) f = 2;
        else if (m % 3 == 0) f = 3;
        else if (m % 5 == 0) f = 5;
        else if (m % 7 == 0) f = 7;
        else f = 1;
        return f * $urandom_range(32'hFFFF_FFFF / f);
      end
      8:          return 32'd0;
      default:    return 32'hFFFF_FFFF - $urandom_range(15);
    endcase
  endfunction

  initial begin
    int idx;
    sb            = new();
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    in_valid      = 1'b0;
    in_value      = '0;
    out_ready     = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Reset modulus: zero, one, extremes, value equal to and above it.
    send_value(32'd0);
    send_value(32'd1);
    send_value(32'd2);
    send_value(32'hFFFF_FFFF);
    send_value(32'd1000000006);
    send_value(32'd1000000007);
    send_value(32'd2000000014);
    // Composite modulus: values sharing a factor.
    write_modulus(32'd12);
    send_value(32'd0);
    send_value(32'd4);
    send_value(32'd5);
    send_value(32'd12);
    send_value(32'hFFFF_FFFF);
    // Modulus one.
    write_modulus(32'd1);
    send_value(32'd0);
    send_value(32'd7);
    send_value(32'hFFFF_FFFF);
    // Largest modulus.
    write_modulus(32'hFFFF_FFFF);
    send_value(32'hFFFF_FFFE);
    send_value(32'd3);
    send_value(32'hFFFF_FFFF);
    send_value(32'h8000_0000);

    idx = 0;
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_modulus(phase_modulus(p));
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (idx < 550) begin
          send_idle_pct = 30;
          recv_idle_pct = 77;
        end else if (idx < 1100) begin
          send_idle_pct = 77;
          recv_idle_pct = 30;
        end else begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        if (idx == 200) hold_requests++;
        if (idx == 900) drain_results();
        send_value(pick_value(sb.modulus));
        idx++;
      end
    end

    drain_results();
    repeat (300) @(negedge clk);

    $display("%0d values sent under %0d modulus settings (1, 2, 2^31, 2^32-1 among them)",
             total_sent, moduli_used);
    $display("%0d results checked, %0d mismatches", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_count() == 0) begin
      $display("modular_inverse_ext_euclid verification clean");
    end else begin
      $display("modular_inverse_ext_euclid verification failed");
    end
    $finish;
  end

endmodule
